// ===== rtl/bmi_pkg.sv =====
`default_nettype none
package bmi_pkg;
  typedef enum logic [2:0] {
    OpBzhi = 3'd0,
    OpPext = 3'd1,
    OpPdep = 3'd2,
    OpMulx = 3'd3,
    OpSarx = 3'd4,
    OpShrx = 3'd5,
    OpShlx = 3'd6,
    OpRorx = 3'd7
  } bmi_op_e;

  localparam logic [63:0] Mask32 = 64'h0000_0000_ffff_ffff;

  // Per-item control that travels down the pipeline next to the data.
  typedef struct packed {
    logic    valid;
    bmi_op_e op;
    logic    wide;
  } bmi_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/bmi_mul.sv =====
`default_nettype none
// Three-stage 64x64 multiplier: 32x32 partial products, then column sums,
// then the final carry into the high half.
module bmi_mul import bmi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] hi_o,
  output logic      [63:0] lo_o
);
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  logic [63:0] lo_q, hi_part_q;
  logic [1:0]  mid_hi_q;
  logic [65:0] mid;

  always_ff @(posedge clk_i) begin
    p00_q <= {32'd0, a_i[31:0]} * {32'd0, b_i[31:0]};
    p01_q <= {32'd0, a_i[31:0]} * {32'd0, b_i[63:32]};
    p10_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};
    p11_q <= {32'd0, a_i[63:32]} * {32'd0, b_i[63:32]};
  end

  assign mid = {34'd0, p00_q[63:32]} + {34'd0, p01_q[31:0]} + {34'd0, p10_q[31:0]};

  always_ff @(posedge clk_i) begin
    lo_q      <= {mid[31:0], p00_q[31:0]};
    mid_hi_q  <= mid[33:32];
    hi_part_q <= p11_q + {32'd0, p01_q[63:32]} + {32'd0, p10_q[63:32]};
  end

  always_ff @(posedge clk_i) begin
    hi_o <= hi_part_q + {62'd0, mid_hi_q};
    lo_o <= lo_q;
  end
endmodule
`default_nettype wire

// ===== rtl/bmi_bitperm.sv =====
`default_nettype none
// Three-stage PEXT/PDEP. Stage one: per-half prefix ranks of the mask,
// stage two: full ranks; stage three moves bits: each result bit picks
// its source bit by rank, so the wide search becomes independent selects.
module bmi_bitperm import bmi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        dep_i,
  input  wire logic [63:0] src_i,
  input  wire logic [63:0] mask_i,
  output logic      [63:0] res_o
);
  logic [63:0]      src_q, mask_q, src2_q, mask2_q;
  logic             dep_q, dep2_q;
  logic [6:0]       cnt_lo_q [32];
  logic [6:0]       cnt_hi_q [32];
  logic [6:0]       rank_q   [64];
  logic [6:0]       rank     [64];
  logic [6:0]       lo_total;
  logic [31:0]      half_lo, half_hi;
  logic [63:0]      res_d;

  // Stage one: ranks within each 32-bit half.
  always_ff @(posedge clk_i) begin
    for (int h = 0; h < 32; h++) begin
      cnt_lo_q[h] <= 7'($countones(mask_i[31:0] & ((64'd1 << h) - 64'd1)));
      cnt_hi_q[h] <= 7'($countones(mask_i[63:32] & ((64'd1 << h) - 64'd1)));
    end
    src_q  <= src_i;
    mask_q <= mask_i;
    dep_q  <= dep_i;
  end

  assign lo_total = 7'($countones(mask_q[31:0]));
  always_comb begin
    for (int m = 0; m < 32; m++) begin
      rank[m]      = cnt_lo_q[m];
      rank[m + 32] = cnt_hi_q[m] + lo_total;
    end
  end

  // Stage two: full ranks.
  always_ff @(posedge clk_i) begin
    rank_q  <= rank;
    src2_q  <= src_q;
    mask2_q <= mask_q;
    dep2_q  <= dep_q;
  end

  // Stage three: bit moves. For deposit, mask bit m takes source bit rank(m).
  // For extract, result bit k is the source bit whose rank is k.
  always_comb begin
    res_d = '0;
    for (int m = 0; m < 64; m++) begin
      if (mask2_q[m]) begin
        if (dep2_q) res_d[m] = src2_q[rank_q[m][5:0]];
        else        res_d[rank_q[m][5:0]] = src2_q[m];
      end
    end
  end
  assign half_lo = res_d[31:0];
  assign half_hi = res_d[63:32];

  always_ff @(posedge clk_i) begin
    res_o <= {half_hi, half_lo};
  end
endmodule
`default_nettype wire

// ===== rtl/bmi_shift.sv =====
`default_nettype none
// BZHI, shifts and rotate, registered over three stages to line up with the
// multiplier; the work itself sits in the first stage.
module bmi_shift import bmi_pkg::*; (
  input  wire logic        clk_i,
  input  wire bmi_op_e     op_i,
  input  wire logic        wide_i,
  input  wire logic [63:0] rm_i,
  input  wire logic [63:0] vx_i,
  input  wire logic [7:0]  imm_i,
  output logic      [63:0] res_o
);
  logic [5:0]  cnt;
  logic [7:0]  idx;
  logic [63:0] wmask, res_d, r1_q, r2_q;
  logic [63:0] sra64, sra32, ror;
  logic [31:0] ror32;

  assign wmask = wide_i ? '1 : Mask32;
  assign cnt   = (op_i == OpRorx) ? (wide_i ? imm_i[5:0] : {1'b0, imm_i[4:0]})
                                  : (wide_i ? vx_i[5:0]  : {1'b0, vx_i[4:0]});
  assign idx   = vx_i[7:0];
  assign sra64 = 64'($signed(rm_i) >>> cnt);
  assign sra32 = {32'd0, 32'($signed(rm_i[31:0]) >>> cnt[4:0])};
  assign ror32 = (rm_i[31:0] >> cnt[4:0]) | (rm_i[31:0] << (6'd32 - {1'b0, cnt[4:0]}));
  assign ror   = wide_i ? ((rm_i >> cnt) | (rm_i << (7'd64 - {1'b0, cnt})))
                        : {32'd0, ror32};

  always_comb begin
    unique case (op_i)
      OpBzhi: res_d = (idx >= (wide_i ? 8'd64 : 8'd32)) ? rm_i
                      : (rm_i & ((64'd1 << idx[5:0]) - 64'd1));
      OpSarx: res_d = wide_i ? sra64 : sra32;
      OpShrx: res_d = (rm_i & wmask) >> cnt;
      OpShlx: res_d = rm_i << cnt;
      OpRorx: res_d = (cnt == 6'd0) ? rm_i : ror;
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    r1_q  <= res_d & wmask;
    r2_q  <= r1_q;
    res_o <= r2_q;
  end
endmodule
`default_nettype wire

// ===== rtl/bmi2_bit_manipulation_unit.sv =====
`default_nettype none
// BMI2 execution unit: BZHI, PEXT, PDEP, MULX, SARX, SHRX, SHLX, RORX.
// The result and its strobe come out of the three-stage multiplier and
// bit-permute pipes plus one output register.
// Throughput: one word per cycle; busy is always low.
// Reset clears the control registers and done_o, not the data; the receiver cannot stall the unit.
module bmi2_bit_manipulation_unit import bmi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind_i,
  input  wire logic        wide_i,
  input  wire logic [63:0] rm_operand_i,
  input  wire logic [63:0] vex_operand_i,
  input  wire logic [63:0] rdx_value_i,
  input  wire logic [7:0]  immediate_i,
  output logic             done_o,
  output logic [63:0]      result_o,
  output logic [63:0]      low_half_o,
  output logic             low_valid_o
);
  bmi_ctl_t    ctl_d, ctl1_q, ctl2_q, ctl3_q;
  logic [63:0] wmask, rm, vx, rdx;
  logic [63:0] mul_hi, mul_lo, perm_res, sh_res, wm3;
  bmi_op_e     op;

  // The pipes never stall, so a new word can always be taken.
  assign busy  = 1'b0;
  assign op    = bmi_op_e'(kind_i);
  assign wmask = wide_i ? '1 : Mask32;
  assign rm    = rm_operand_i & wmask;
  assign vx    = vex_operand_i & wmask;
  assign rdx   = rdx_value_i & wmask;

  assign ctl_d = '{valid: start, op: op, wide: wide_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '{valid: 1'b0, op: OpBzhi, wide: 1'b0};
      ctl2_q <= '{valid: 1'b0, op: OpBzhi, wide: 1'b0};
      ctl3_q <= '{valid: 1'b0, op: OpBzhi, wide: 1'b0};
      done_o <= 1'b0;
    end else begin
      ctl1_q <= ctl_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      done_o <= ctl3_q.valid;
    end
  end

  bmi_mul u_mul (
    .clk_i(clk_i), .a_i(rdx), .b_i(rm), .hi_o(mul_hi), .lo_o(mul_lo)
  );

  bmi_bitperm u_perm (
    .clk_i(clk_i), .dep_i(op == OpPdep), .src_i(vx), .mask_i(rm), .res_o(perm_res)
  );

  bmi_shift u_shift (
    .clk_i(clk_i), .op_i(op), .wide_i(wide_i), .rm_i(rm), .vx_i(vx),
    .imm_i(immediate_i), .res_o(sh_res)
  );

  // In 32-bit mode the 64-bit product of the cut operands splits at bit 32.
  assign wm3 = ctl3_q.wide ? '1 : Mask32;

  always_ff @(posedge clk_i) begin
    unique case (ctl3_q.op)
      OpMulx: begin
        result_o    <= ctl3_q.wide ? mul_hi : {32'd0, mul_lo[63:32]};
        low_half_o  <= mul_lo & wm3;
        low_valid_o <= 1'b1;
      end
      OpPext, OpPdep: begin
        result_o    <= perm_res & wm3;
        low_half_o  <= '0;
        low_valid_o <= 1'b0;
      end
      default: begin
        result_o    <= sh_res;
        low_half_o  <= '0;
        low_valid_o <= 1'b0;
      end
    endcase
  end

  // Every accepted word is followed by a result strobe, and no strobe comes without one.
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 done_o) else $error("missing result strobe");
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4)) else $error("spurious result strobe");
  a_lowv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !low_valid_o) |-> (low_half_o == 64'd0))
    else $error("low half set without mulx");
endmodule
`default_nettype wire
